>>> design/gmm_pkg.sv
// Shared types, constants and fixed-point helpers for the matrix multiply block.
`default_nettype none
package gmm_pkg;
  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int SIZE_W    = 5;
  localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int WORD_W    = 32;
  localparam int PADDR_W   = 5;

  localparam logic signed [WORD_W-1:0] FX_ONE  = WORD_W'(64'd1 << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] FX_ZERO = '0;

  typedef enum logic [2:0] {
    CMD_LOAD_A  = 3'd0,
    CMD_LOAD_B  = 3'd1,
    CMD_LOAD_C  = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_READ_C  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ALPHA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_TRANS_A = 3'd2,
    REG_TRANS_B = 3'd3,
    REG_ROWS    = 3'd4,
    REG_COLS    = 3'd5,
    REG_INNER   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CRD,
    ST_CDAT,
    ST_CW1,
    ST_CW2,
    ST_KSTART,
    ST_ABRD,
    ST_ABDAT,
    ST_T1,
    ST_T2,
    ST_U1,
    ST_U2,
    ST_CWR,
    ST_DONE
  } state_t;

  function automatic logic signed [WORD_W-1:0] sat_add(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(
    input logic [DIM_W-1:0] r,
    input logic [DIM_W-1:0] c
  );
    elem_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  function automatic logic [SIZE_W-1:0] eff_dim(input logic [SIZE_W-1:0] v);
    eff_dim = (v > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : v;
  endfunction
endpackage
`default_nettype wire

>>> design/gmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module gmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/gmm_fxmul.sv
// Two-stage fixed-point multiplier: product, then round half up and saturate.
`default_nettype none
module gmm_fxmul import gmm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [WORD_W-1:0] x,
  input  wire logic signed [WORD_W-1:0] y,
  output logic signed      [WORD_W-1:0] res_r
);
  localparam int PW = 2 * WORD_W;
  localparam logic [PW:0] RND = (PW+1)'((65'd1 << FRAC_BITS) >> 1);

  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   q;
  logic signed [PW:0]   sh;
  logic signed [WORD_W-1:0] res_nxt;

  always_comb begin
    q  = {prod_r[PW-1], prod_r} + $signed(RND);
    sh = q >>> FRAC_BITS;
    if (sh > $signed({{(PW-WORD_W+2){1'b0}}, {(WORD_W-1){1'b1}}})) begin
      res_nxt = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (sh < $signed({{(PW-WORD_W+2){1'b1}}, {(WORD_W-1){1'b0}}})) begin
      res_nxt = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res_nxt = sh[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= x * y;
    res_r  <= res_nxt;
  end
endmodule
`default_nettype wire

>>> design/general_matrix_multiply.sv
// Top level: register file, A/B/C stores and the compute sequencer.
//
//  channel | ports                          | transfer when
//  in      | in_valid/in_stall, cmd,row,... | in_valid & !in_stall
//  out     | out_valid/out_stall, fields    | out_valid & !out_stall
//  cfg     | APB psel/penable/pwrite/...    | psel & penable & pwrite
//
// Load items and bad items are answered from idle; a read of C passes through
// ST_RD (store read). Compute adds a beta*c multiply per element when beta is
// neither 0 nor 1.0, and skips the terms when alpha is 0: one shared multiplier
// runs alpha*a then t*b for every term, and the A and B stores are re-read per
// term. Reset is synchronous; stores are not cleared. A stalled result holds
// input stall high.
`default_nettype none
module general_matrix_multiply import gmm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic [3:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_echo_command,
  output logic signed [31:0]      out_element,
  output logic                    out_status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  logic signed [WORD_W-1:0] alpha_r, beta_r;
  logic                     trans_a_r, trans_b_r;
  logic [SIZE_W-1:0]        rows_r, cols_r, inner_r;

  state_t state_r, state_nxt;
  logic [DIM_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] req_row_r, req_col_r;
  logic signed [WORD_W-1:0] acc_r, acc_nxt, b_r, b_nxt;
  logic out_valid_r, out_load, out_free;
  logic [2:0] out_cmd_r, out_cmd_nxt;
  logic signed [WORD_W-1:0] out_elem_r, out_elem_nxt;
  logic out_status_r, out_status_nxt;

  logic [SIZE_W-1:0] m, n, kl, lim_r, lim_c;
  logic accept, in_bounds, cmd_bad;
  logic [DIM_W-1:0] row_i, col_i;

  logic we_a, we_b, we_c;
  logic [ADDR_W-1:0] raddr_a, raddr_b, raddr_c, waddr_c, in_addr;
  logic [WORD_W-1:0] rdata_a, rdata_b, rdata_c, wdata_c;
  logic signed [WORD_W-1:0] mul_x, mul_y, mul_res;
  logic last_k, last_j, last_i;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= FX_ONE;
      beta_r    <= FX_ZERO;
      trans_a_r <= 1'b0;
      trans_b_r <= 1'b0;
      rows_r    <= SIZE_W'(MAX_DIM);
      cols_r    <= SIZE_W'(MAX_DIM);
      inner_r   <= SIZE_W'(MAX_DIM);
    end else if (psel && penable && pwrite) begin
      case (paddr[PADDR_W-1:2])
        REG_ALPHA:   alpha_r   <= pwdata;
        REG_BETA:    beta_r    <= pwdata;
        REG_TRANS_A: trans_a_r <= pwdata[0];
        REG_TRANS_B: trans_b_r <= pwdata[0];
        REG_ROWS:    rows_r    <= pwdata[SIZE_W-1:0];
        REG_COLS:    cols_r    <= pwdata[SIZE_W-1:0];
        REG_INNER:   inner_r   <= pwdata[SIZE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_ALPHA:   prdata = alpha_r;
      REG_BETA:    prdata = beta_r;
      REG_TRANS_A: prdata = {31'd0, trans_a_r};
      REG_TRANS_B: prdata = {31'd0, trans_b_r};
      REG_ROWS:    prdata = {27'd0, rows_r};
      REG_COLS:    prdata = {27'd0, cols_r};
      REG_INNER:   prdata = {27'd0, inner_r};
      default:     prdata = '0;
    endcase
  end

  // item decode and bounds
  assign m  = eff_dim(rows_r);
  assign n  = eff_dim(cols_r);
  assign kl = eff_dim(inner_r);
  assign row_i = DIM_W'(in_row);
  assign col_i = DIM_W'(in_col);

  always_comb begin
    lim_r   = '0;
    lim_c   = '0;
    cmd_bad = 1'b0;
    case (in_command)
      CMD_LOAD_A: begin
        lim_r = trans_a_r ? kl : m;
        lim_c = trans_a_r ? m : kl;
      end
      CMD_LOAD_B: begin
        lim_r = trans_b_r ? n : kl;
        lim_c = trans_b_r ? kl : n;
      end
      CMD_LOAD_C, CMD_READ_C: begin
        lim_r = m;
        lim_c = n;
      end
      CMD_COMPUTE: ;
      default: cmd_bad = 1'b1;
    endcase
  end

  assign in_bounds = (SIZE_W'(in_row) < lim_r) && (SIZE_W'(in_col) < lim_c);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign in_addr   = elem_addr(row_i, col_i);

  assign last_k = (SIZE_W'(k_r) == kl - SIZE_W'(1));
  assign last_j = (SIZE_W'(j_r) == n - SIZE_W'(1));
  assign last_i = (SIZE_W'(i_r) == m - SIZE_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_COMPUTE) begin
          state_nxt = (m == '0 || n == '0) ? ST_DONE : ST_CRD;
        end else if (accept && in_command == CMD_READ_C && in_bounds) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:     if (out_free) state_nxt = ST_IDLE;
      ST_CRD:    state_nxt = ST_CDAT;
      ST_CDAT: begin
        if (beta_r == FX_ZERO || beta_r == FX_ONE) state_nxt = ST_KSTART;
        else state_nxt = ST_CW1;
      end
      ST_CW1:    state_nxt = ST_CW2;
      ST_CW2:    state_nxt = ST_KSTART;
      ST_KSTART: state_nxt = (alpha_r == FX_ZERO || kl == '0) ? ST_CWR : ST_ABRD;
      ST_ABRD:   state_nxt = ST_ABDAT;
      ST_ABDAT:  state_nxt = ST_T1;
      ST_T1:     state_nxt = ST_T2;
      ST_T2:     state_nxt = ST_U1;
      ST_U1:     state_nxt = ST_U2;
      ST_U2:     state_nxt = last_k ? ST_CWR : ST_ABRD;
      ST_CWR:    state_nxt = (last_i && last_j) ? ST_DONE : ST_CRD;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    mul_x    = beta_r;
    mul_y    = rdata_c;
    out_load = 1'b0;
    out_cmd_nxt    = in_command;
    out_elem_nxt   = FX_ZERO;
    out_status_nxt = 1'b0;
    we_a = 1'b0;
    we_b = 1'b0;
    we_c = 1'b0;
    waddr_c = in_addr;
    wdata_c = in_value;
    raddr_c = in_addr;
    raddr_a = in_addr;
    raddr_b = in_addr;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (accept && in_command != CMD_COMPUTE &&
            !(in_command == CMD_READ_C && in_bounds)) begin
          out_load = 1'b1;
          out_status_nxt = cmd_bad || !in_bounds;
          we_a = in_bounds && in_command == CMD_LOAD_A;
          we_b = in_bounds && in_command == CMD_LOAD_B;
          we_c = in_bounds && in_command == CMD_LOAD_C;
        end
      end
      ST_RD: begin
        raddr_c = elem_addr(req_row_r, req_col_r);
        out_load = out_free;
        out_cmd_nxt = CMD_READ_C;
        out_elem_nxt = rdata_c;
      end
      ST_DONE: begin
        out_load = out_free;
        out_cmd_nxt = CMD_COMPUTE;
      end
      default: begin
        raddr_c = elem_addr(i_r, j_r);
        raddr_a = trans_a_r ? elem_addr(k_r, i_r) : elem_addr(i_r, k_r);
        raddr_b = trans_b_r ? elem_addr(j_r, k_r) : elem_addr(k_r, j_r);
        waddr_c = elem_addr(i_r, j_r);
        wdata_c = acc_r;
        unique case (state_r)
          ST_CDAT: begin
            if (beta_r == FX_ZERO) acc_nxt = FX_ZERO;
            else acc_nxt = rdata_c;
          end
          ST_CW2:    acc_nxt = mul_res;
          ST_KSTART: k_nxt = '0;
          ST_ABDAT: begin
            mul_x = alpha_r;
            mul_y = rdata_a;
            b_nxt = rdata_b;
          end
          ST_T2: begin
            mul_x = mul_res;
            mul_y = b_r;
          end
          ST_U2: begin
            acc_nxt = sat_add(acc_r, mul_res);
            k_nxt = k_r + DIM_W'(1);
          end
          ST_CWR: begin
            we_c = 1'b1;
            if (last_j) begin
              j_nxt = '0;
              i_nxt = i_r + DIM_W'(1);
            end else begin
              j_nxt = j_r + DIM_W'(1);
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    if (accept) begin
      req_row_r <= row_i;
      req_col_r <= col_i;
    end
    if (out_load) begin
      out_cmd_r    <= out_cmd_nxt;
      out_elem_r   <= out_elem_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_echo_command = out_cmd_r;
  assign out_element      = out_elem_r;
  assign out_status       = out_status_r;

  gmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_a (
    .clk(clk), .we(we_a), .waddr(in_addr), .wdata(in_value),
    .raddr(raddr_a), .rdata(rdata_a)
  );

  gmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_b (
    .clk(clk), .we(we_b), .waddr(in_addr), .wdata(in_value),
    .raddr(raddr_b), .rdata(rdata_b)
  );

  gmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_c (
    .clk(clk), .we(we_c), .waddr(waddr_c), .wdata(wdata_c),
    .raddr(raddr_c), .rdata(rdata_c)
  );

  gmm_fxmul u_mul (
    .clk(clk), .x(mul_x), .y(mul_y), .res_r(mul_res)
  );
endmodule
`default_nettype wire
